FILE: sv/lcs_pkg.sv
// Shared types, sizes and codes of the longest common substring core.
package lcs_pkg;

	localparam int SECOND_MAX  = 64;
	localparam int FIRST_MAX   = 256;

	localparam int SEC_CNT_W   = $clog2(SECOND_MAX + 1);
	localparam int SEC_IDX_W   = (SECOND_MAX > 1) ? $clog2(SECOND_MAX) : 1;
	localparam int FIRST_CNT_W = $clog2(FIRST_MAX + 1);
	localparam int FIRST_IDX_W = (FIRST_MAX > 1) ? $clog2(FIRST_MAX) : 1;
	localparam int LEN_W       = 7;
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NEED_BUF = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

	localparam logic SEL_SECOND = 1'b0;
	localparam logic SEL_FIRST  = 1'b1;

	localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic              string_sel;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} lcs_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    match_length;
		logic [CHAR_W-1:0]   out_char;
		logic                has_char;
		logic                truncated;
		logic                last_out;
	} lcs_result_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic              clear;
		logic              row_en;
		logic [CHAR_W-1:0] ch;
		logic [LEN_W-1:0]  best;
	} lcs_cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FINISH,
		ST_READ,
		ST_LOAD
	} lcs_state_t;

endpackage

FILE: sv/lcs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/lcs_cell.sv
// One column of the DP row: holds a second-string byte and its current length.
module lcs_cell import lcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcs_cell_ctrl_t        ctrl,
	input  logic                  load,
	input  logic [LEN_W-1:0]      diag,
	output logic [LEN_W-1:0]      len,
	output logic                  hit,
	output logic                  active
);

	logic              valid_q;
	logic [CHAR_W-1:0] byte_q;
	logic [LEN_W-1:0]  len_q;
	logic              match;

	assign match = valid_q && (byte_q == ctrl.ch);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			len_q   <= '0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
			len_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end
			if (ctrl.row_en && valid_q) begin
				len_q <= match ? diag + LEN_W'(1) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= ctrl.ch;
		end
	end

	// new length can beat the best only by one, so equality with best is enough
	assign hit    = ctrl.row_en && match && (diag == ctrl.best);
	assign len    = len_q;
	assign active = valid_q;

endmodule

FILE: sv/longest_common_substring_core.sv
// Longest common substring core: a row of DP cells, first-string RAM and result sequencer.
//
// Load the second string (string_sel 0) and then stream the first string
// (string_sel 1, last on its final byte); every column of the DP row updates
// at once in its own cell. Bytes past 64 (second) or 256 (first) are dropped
// and reported as truncated. After the last byte the input is stalled: the
// finish state picks the outcome; then a status result goes out when the
// output is free, or each substring byte is read from the first-string RAM
// in a read state and loaded in a load state, which waits on any result stall.
// The input is taken again once the final result sits in the output register.
module longest_common_substring_core import lcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  lcs_item_t         char_item,
	output logic              res_valid,
	input  logic              res_stall,
	output lcs_result_t       res_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data
);

	lcs_state_t state_q, state_d;

	logic [SEC_CNT_W-1:0]   second_cnt_q;
	logic [FIRST_CNT_W-1:0] first_cnt_q;
	logic [LEN_W-1:0]       best_q;
	logic [FIRST_IDX_W-1:0] best_row_q;
	logic                   overflow_q;
	logic [LEN_W-1:0]       buf_cap_q;
	logic [FIRST_IDX_W-1:0] rd_addr_q;
	logic [LEN_W-1:0]       remain_q;
	lcs_result_t            res_q;
	logic                   res_valid_q;

	logic                   accept;
	logic                   second_wr;
	logic                   first_wr;
	logic                   drop;
	logic                   out_free;
	logic                   short_res;
	logic                   res_load;
	lcs_result_t            res_next;
	logic                   run_clear;
	logic                   start_set;
	logic                   emit_step;
	logic                   row_hit;
	logic [CHAR_W-1:0]      ram_rdata;
	lcs_cell_ctrl_t         cell_ctrl;

	logic [LEN_W-1:0]       cell_len [SECOND_MAX];
	logic [SECOND_MAX-1:0]  cell_hit;
	logic [SECOND_MAX-1:0]  cell_active;

	assign cfg_ready = 1'b1;
	assign accept    = char_valid && !char_stall;
	assign second_wr = accept && (char_item.string_sel == SEL_SECOND)
	                   && (second_cnt_q < SEC_CNT_W'(SECOND_MAX));
	assign first_wr  = accept && (char_item.string_sel == SEL_FIRST)
	                   && (first_cnt_q < FIRST_CNT_W'(FIRST_MAX));
	assign drop      = accept && !second_wr && !first_wr;
	assign out_free  = !res_valid_q || !res_stall;
	assign short_res = (first_cnt_q == '0) || (second_cnt_q == '0) || (best_q == '0)
	                   || (buf_cap_q < best_q);
	assign row_hit   = |cell_hit;

	assign cell_ctrl.clear  = run_clear;
	assign cell_ctrl.row_en = first_wr;
	assign cell_ctrl.ch     = char_item.ch;
	assign cell_ctrl.best   = best_q;

	for (genvar j = 0; j < SECOND_MAX; j++) begin : g_cell
		logic [LEN_W-1:0] diag;
		if (j == 0) begin : g_first
			assign diag = '0;
		end else begin : g_rest
			assign diag = cell_len[j-1];
		end
		lcs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.load   (second_wr && (second_cnt_q[SEC_IDX_W-1:0] == SEC_IDX_W'(j))),
			.diag   (diag),
			.len    (cell_len[j]),
			.hit    (cell_hit[j]),
			.active (cell_active[j])
		);
	end

	lcs_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (FIRST_MAX)
	) u_first_ram (
		.clk   (clk),
		.we    (first_wr),
		.waddr (first_cnt_q[FIRST_IDX_W-1:0]),
		.wdata (char_item.ch),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (char_item.string_sel == SEL_FIRST) && char_item.last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!short_res) begin
					state_d = ST_READ;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					state_d = (remain_q == LEN_W'(1)) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		char_stall            = (state_q != ST_IDLE);
		res_load              = 1'b0;
		run_clear             = 1'b0;
		start_set             = 1'b0;
		emit_step             = 1'b0;
		res_next.status       = STATUS_OK;
		res_next.match_length = best_q;
		res_next.out_char     = '0;
		res_next.has_char     = 1'b0;
		res_next.truncated    = overflow_q;
		res_next.last_out     = 1'b1;
		case (state_q)
			ST_FINISH: begin
				start_set = 1'b1;
				if (short_res && out_free) begin
					res_load  = 1'b1;
					run_clear = 1'b1;
					if ((first_cnt_q == '0) || (second_cnt_q == '0)) begin
						res_next.status       = STATUS_EMPTY;
						res_next.match_length = '0;
					end else if (best_q != '0) begin
						res_next.status = STATUS_NEED_BUF;
					end
				end
			end
			ST_LOAD: begin
				res_next.out_char = ram_rdata;
				res_next.has_char = 1'b1;
				res_next.last_out = (remain_q == LEN_W'(1));
				if (out_free) begin
					res_load  = 1'b1;
					emit_step = 1'b1;
					run_clear = (remain_q == LEN_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			second_cnt_q <= '0;
			first_cnt_q  <= '0;
			best_q       <= '0;
			best_row_q   <= '0;
			overflow_q   <= 1'b0;
			buf_cap_q    <= CAP_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				buf_cap_q <= cfg_data;
			end
			if (run_clear) begin
				second_cnt_q <= '0;
				first_cnt_q  <= '0;
				best_q       <= '0;
				best_row_q   <= '0;
				overflow_q   <= 1'b0;
			end else begin
				if (second_wr) begin
					second_cnt_q <= second_cnt_q + SEC_CNT_W'(1);
				end
				if (first_wr) begin
					first_cnt_q <= first_cnt_q + FIRST_CNT_W'(1);
					if (row_hit) begin
						best_q     <= best_q + LEN_W'(1);
						best_row_q <= first_cnt_q[FIRST_IDX_W-1:0];
					end
				end
				if (drop) begin
					overflow_q <= 1'b1;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_next;
		end
		if (start_set) begin
			rd_addr_q <= best_row_q + FIRST_IDX_W'(1) - FIRST_IDX_W'(best_q);
			remain_q  <= best_q;
		end else if (emit_step) begin
			rd_addr_q <= rd_addr_q + FIRST_IDX_W'(1);
			remain_q  <= remain_q - LEN_W'(1);
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// loaded cells and the byte count must agree
	a_cells_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_active) == 32'(second_cnt_q))
		else $error("cell valid bits disagree with second string count");

	a_best_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= LEN_W'(second_cnt_q))
		else $error("best length exceeds second string length");

	a_emit_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_LOAD) |-> remain_q != '0)
		else $error("emitting with no bytes left");

	a_char_result_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.has_char) |->
		(res_item.status == STATUS_OK && res_item.match_length != '0))
		else $error("substring byte with bad status or length");

	a_hit_only_on_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_hit |-> first_wr)
		else $error("best length update without a first string byte");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the longest common substring core.
module testbench;
	import lcs_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_SHOWN     = 10;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             char_valid = 1'b0;
	logic             char_stall;
	lcs_item_t        char_item  = '0;
	logic             res_valid;
	logic             res_stall  = 1'b0;
	lcs_result_t      res_item;
	logic             cfg_valid  = 1'b0;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data   = '0;

	longest_common_substring_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// substring predictor state
	logic [CHAR_W-1:0] second_bytes [SECOND_MAX];
	logic [CHAR_W-1:0] first_bytes  [FIRST_MAX];
	logic [LEN_W-1:0]  col_len      [SECOND_MAX];
	int                second_len = 0;
	int                first_len  = 0;
	int                best_len   = 0;
	int                best_row   = 0;
	logic              dropped    = 1'b0;
	logic [LEN_W-1:0]  capacity   = CAP_RESET;
	lcs_result_t       expected_results [$];

	logic [CHAR_W-1:0] sec_q [$];
	logic [CHAR_W-1:0] fst_q [$];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_left    = 0;

	int items_sent      = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int cfg_writes      = 0;
	int runs_total      = 0;
	int runs_matched    = 0;
	int runs_short_buf  = 0;
	int runs_no_match   = 0;
	int runs_empty      = 0;
	int runs_truncated  = 0;

	initial begin
		for (int j = 0; j < SECOND_MAX; j++)
			col_len[j] = '0;
	end

	// one DP row per first-string byte; results only when the run ends
	function automatic void predict_substring(input lcs_item_t it);
		logic [LEN_W-1:0] fresh [SECOND_MAX];
		lcs_result_t      r;
		int               start;
		if (it.string_sel == SEL_SECOND) begin
			if (second_len < SECOND_MAX) begin
				second_bytes[second_len] = it.ch;
				second_len++;
			end else begin
				dropped = 1'b1;
			end
			return;
		end
		if (first_len < FIRST_MAX) begin
			first_bytes[first_len] = it.ch;
			for (int j = 0; j < second_len; j++) begin
				if (second_bytes[j] == it.ch)
					fresh[j] = (j == 0 ? 7'd0 : col_len[j-1]) + 7'd1;
				else
					fresh[j] = 7'd0;
			end
			for (int j = 0; j < second_len; j++) begin
				col_len[j] = fresh[j];
				if (fresh[j] > best_len) begin
					best_len = fresh[j];
					best_row = first_len;
				end
			end
			first_len++;
		end else begin
			dropped = 1'b1;
		end
		if (!it.last)
			return;

		runs_total++;
		if (dropped)
			runs_truncated++;
		r           = '0;
		r.truncated = dropped;
		if (first_len == 0 || second_len == 0) begin
			r.status   = STATUS_EMPTY;
			r.last_out = 1'b1;
			expected_results.push_back(r);
			runs_empty++;
		end else if (best_len == 0) begin
			r.status   = STATUS_OK;
			r.last_out = 1'b1;
			expected_results.push_back(r);
			runs_no_match++;
		end else if (capacity < best_len) begin
			r.status       = STATUS_NEED_BUF;
			r.match_length = LEN_W'(best_len);
			r.last_out     = 1'b1;
			expected_results.push_back(r);
			runs_short_buf++;
		end else begin
			start = best_row + 1 - best_len;
			for (int k = 0; k < best_len; k++) begin
				r.status       = STATUS_OK;
				r.match_length = LEN_W'(best_len);
				r.out_char     = first_bytes[start + k];
				r.has_char     = 1'b1;
				r.last_out     = (k == best_len - 1);
				expected_results.push_back(r);
			end
			runs_matched++;
		end
		for (int j = 0; j < SECOND_MAX; j++)
			col_len[j] = '0;
		second_len = 0;
		first_len  = 0;
		best_len   = 0;
		best_row   = 0;
		dropped    = 1'b0;
	endfunction

	task automatic note_mismatch(input string what, input lcs_result_t want,
			input lcs_result_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t %s: exp st=%0d len=%0d ch=%02h has=%0b tr=%0b last=%0b",
				$time, what, want.status, want.match_length, want.out_char,
				want.has_char, want.truncated, want.last_out,
				" got st=%0d len=%0d ch=%02h has=%0b tr=%0b last=%0b",
				got.status, got.match_length, got.out_char,
				got.has_char, got.truncated, got.last_out);
	endtask

	// result checker
	always @(posedge clk) begin
		lcs_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result", '0, res_item);
			end else begin
				want = expected_results.pop_front();
				if (res_item.status !== want.status
						|| res_item.match_length !== want.match_length
						|| res_item.out_char !== want.out_char
						|| res_item.has_char !== want.has_char
						|| res_item.truncated !== want.truncated
						|| res_item.last_out !== want.last_out)
					note_mismatch("field mismatch", want, res_item);
			end
		end
	end

	// result side: random stalls, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_char(input lcs_item_t it);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= it;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		predict_substring(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic put_byte(input logic sel, input logic [CHAR_W-1:0] c, input logic lst);
		lcs_item_t it;
		it.string_sel = sel;
		it.ch         = c;
		it.last       = lst;
		send_char(it);
	endtask

	// second string from sec_q, then first string from fst_q ending the run
	task automatic send_run();
		foreach (sec_q[i])
			put_byte(SEL_SECOND, sec_q[i], 1'b0);
		foreach (fst_q[i])
			put_byte(SEL_FIRST, fst_q[i], i == fst_q.size() - 1);
		sec_q.delete();
		fst_q.delete();
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [LEN_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		capacity = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_run();
		int               n2, pre, tail, off, slen, span, n;
		logic [CHAR_W-1:0] base;
		// noise: arbitrary bytes, then a first-string byte that closes the run
		if ($urandom_range(0, 99) < 15) begin
			n = $urandom_range(1, 10);
			for (int j = 0; j < n; j++)
				put_byte(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			put_byte(SEL_FIRST, CHAR_W'($urandom_range(0, 255)), 1'b1);
			return;
		end
		base = CHAR_W'($urandom_range(0, 255));
		span = $urandom_range(0, 3);
		n2   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, SECOND_MAX)
			: $urandom_range(1, 12);
		for (int j = 0; j < n2; j++)
			sec_q.push_back(base + CHAR_W'($urandom_range(0, span)));
		if ($urandom_range(0, 1)) begin
			pre  = $urandom_range(0, 4);
			tail = $urandom_range(0, 4);
			off  = $urandom_range(0, n2 - 1);
			slen = $urandom_range(1, n2 - off);
			for (int j = 0; j < pre; j++)
				fst_q.push_back(base + CHAR_W'($urandom_range(0, span + 1)));
			for (int j = 0; j < slen; j++)
				fst_q.push_back(sec_q[off + j]);
			for (int j = 0; j < tail; j++)
				fst_q.push_back(base + CHAR_W'($urandom_range(0, span + 1)));
		end else begin
			n = $urandom_range(1, 16);
			for (int j = 0; j < n; j++)
				fst_q.push_back(base + CHAR_W'($urandom_range(0, span + 1)));
		end
		send_run();
	endtask

	task automatic test_basic_cases();
		// byte extremes
		sec_q = '{8'h00, 8'hFF};
		fst_q = '{8'h00, 8'hFF};
		send_run();
		// last on a second-string byte has no effect; no match follows
		put_byte(SEL_SECOND, 8'h55, 1'b1);
		put_byte(SEL_SECOND, 8'hAA, 1'b0);
		put_byte(SEL_FIRST, 8'h5A, 1'b0);
		put_byte(SEL_FIRST, 8'hA5, 1'b1);
		// empty second string
		put_byte(SEL_FIRST, 8'h80, 1'b1);
		// second-string byte arriving after first-string bytes
		put_byte(SEL_SECOND, 8'h41, 1'b0);
		put_byte(SEL_FIRST, 8'h42, 1'b0);
		put_byte(SEL_SECOND, 8'h43, 1'b1);
		put_byte(SEL_FIRST, 8'h43, 1'b1);
		// tie: earliest row wins
		sec_q = '{8'h41, 8'h42};
		fst_q = '{8'h42, 8'h41};
		send_run();
	endtask

	task automatic test_buffer_capacity();
		write_capacity(7'd0);
		sec_q = '{8'h07};
		fst_q = '{8'h07};
		send_run();
		write_capacity(7'd2);
		sec_q = '{8'h01, 8'h02, 8'h03};
		fst_q = '{8'h01, 8'h02, 8'h03};
		send_run();
		sec_q = '{8'h01, 8'h02};
		fst_q = '{8'h09, 8'h01, 8'h02};
		send_run();
		write_capacity(7'd1);
		sec_q = '{8'h05};
		fst_q = '{8'h05};
		send_run();
	endtask

	task automatic test_store_overflow();
		logic [CHAR_W-1:0] c;
		write_capacity(7'd64);
		// full-width match, the longest result burst, with both stores overrun;
		// the final first-string byte is among the dropped ones
		for (int j = 0; j < SECOND_MAX; j++) begin
			c = CHAR_W'($urandom_range(0, 255));
			sec_q.push_back(c);
			fst_q.push_back(c);
		end
		for (int j = 0; j < 2; j++)
			sec_q.push_back(CHAR_W'($urandom_range(0, 255)));
		for (int j = SECOND_MAX; j < FIRST_MAX + 2; j++)
			fst_q.push_back(CHAR_W'($urandom_range(0, 255)));
		send_run();
	endtask

	task automatic test_result_backpressure();
		logic [CHAR_W-1:0] base;
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		// runs offered back to back while results cannot drain
		for (int r = 0; r < 5; r++) begin
			base = CHAR_W'($urandom_range(0, 255));
			for (int j = 0; j < 3; j++)
				sec_q.push_back(base + CHAR_W'($urandom_range(0, 1)));
			for (int j = 0; j < 5; j++)
				fst_q.push_back(base + CHAR_W'($urandom_range(0, 1)));
			send_run();
		end
		wait_drained();
	endtask

	task automatic test_random_runs(input int n_items, input logic [LEN_W-1:0] cap);
		int start;
		write_capacity(cap);
		start = items_sent;
		while (items_sent - start < n_items) begin
			random_run();
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		snd_idle_pct = 20;
		rcv_idle_pct = 59;
		test_basic_cases();
		test_buffer_capacity();
		test_random_runs(8, 7'd64);

		snd_idle_pct = 59;
		rcv_idle_pct = 20;
		test_store_overflow();
		test_random_runs(8, 7'd5);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_result_backpressure();
		test_random_runs(8, 7'd40);

		wait_drained();
		repeat (20) @(negedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			mismatches += expected_results.size();
		end

		$display("Covered %0d input bytes, %0d results, %0d runs, %0d capacity writes.",
			items_sent, results_checked, runs_total, cfg_writes);
		$display("Runs: %0d matched, %0d short buffer, %0d no match, %0d empty, %0d truncated.",
			runs_matched, runs_short_buf, runs_no_match, runs_empty, runs_truncated);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Timed out with %0d results outstanding", expected_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
